// ===== rtl/biu_pkg.sv =====
package biu_pkg;

  localparam int unsigned SrcDim     = 256;
  localparam int unsigned DstDim     = 4096;
  localparam int unsigned CoordW     = 8;
  localparam int unsigned SrcSizeW   = 9;
  localparam int unsigned DstSizeW   = 13;
  localparam int unsigned ReqW       = 12;
  localparam int unsigned NumW       = 22;
  localparam int unsigned DenW       = 14;
  localparam int unsigned RemW       = 30;
  localparam int unsigned QuotW      = 16;
  localparam int unsigned BankAddrW  = 14;
  localparam int unsigned BankDepth  = 16384;
  localparam int unsigned CfgIndexW  = 8;
  localparam int unsigned CfgDataW   = 13;

  localparam logic [CfgIndexW-1:0] CFG_SRC_WIDTH  = 8'd0;
  localparam logic [CfgIndexW-1:0] CFG_SRC_HEIGHT = 8'd1;
  localparam logic [CfgIndexW-1:0] CFG_DST_WIDTH  = 8'd2;
  localparam logic [CfgIndexW-1:0] CFG_DST_HEIGHT = 8'd3;

  localparam logic OP_LOAD    = 1'b0;
  localparam logic OP_REQUEST = 1'b1;

  typedef struct packed {
    logic        operation;
    logic [7:0]  load_x;
    logic [7:0]  load_y;
    logic [7:0]  load_red;
    logic [7:0]  load_green;
    logic [7:0]  load_blue;
    logic [11:0] req_x;
    logic [11:0] req_y;
  } in_item_t;

  typedef struct packed {
    logic [7:0] out_red;
    logic [7:0] out_green;
    logic [7:0] out_blue;
  } out_item_t;

  typedef struct packed {
    logic        op;
    logic [7:0]  lx;
    logic [7:0]  ly;
    logic [23:0] rgb;
  } load_t;

  typedef struct packed {
    load_t               ld;
    logic [SrcSizeW-1:0] sw;
    logic [SrcSizeW-1:0] sh;
    logic [DenW-1:0]     denx;
    logic [DenW-1:0]     deny;
    logic                ovfx;
    logic                ovfy;
    logic [RemW-1:0]     remx;
    logic [RemW-1:0]     remy;
    logic [QuotW-1:0]    qx;
    logic [QuotW-1:0]    qy;
  } div_t;

endpackage

// ===== rtl/bilinear_image_upsampler.sv =====
// A request item passes through stage 0, divider setup, the 16-stage restoring
// divider per axis that finds the source position, stages A, M and P and the
// output register; one item per cycle while the output is not stalled. The four
// neighbors come from four row/column-parity banks read in the same cycle.
// Reset clears valid bits and sets the size registers to 256; the source
// store is not cleared and must be loaded before it is read.
module bilinear_image_upsampler (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                in_valid_i,
  output logic                                in_stall_o,
  input  biu_pkg::in_item_t                   in_item_i,
  output logic                                out_valid_o,
  input  logic                                out_stall_i,
  output biu_pkg::out_item_t                  out_item_o,
  input  logic                                cfg_valid_i,
  output logic                                cfg_ready_o,
  input  logic [biu_pkg::CfgIndexW-1:0]       cfg_index_i,
  input  logic [biu_pkg::CfgDataW-1:0]        cfg_data_i
);
  import biu_pkg::*;

  logic en;
  assign en          = !(out_valid_o && out_stall_i);
  assign in_stall_o  = !en;
  assign cfg_ready_o = 1'b1;

  // configuration
  logic [SrcSizeW-1:0] src_w_q, src_h_q;
  logic [DstSizeW-1:0] dst_w_q, dst_h_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      src_w_q <= SrcSizeW'(SrcDim);
      src_h_q <= SrcSizeW'(SrcDim);
      dst_w_q <= DstSizeW'(SrcDim);
      dst_h_q <= DstSizeW'(SrcDim);
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        CFG_SRC_WIDTH:  src_w_q <= cfg_data_i[SrcSizeW-1:0];
        CFG_SRC_HEIGHT: src_h_q <= cfg_data_i[SrcSizeW-1:0];
        CFG_DST_WIDTH:  dst_w_q <= cfg_data_i;
        CFG_DST_HEIGHT: dst_h_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  logic [SrcSizeW-1:0] sw, sh;
  logic [DstSizeW-1:0] dw, dh;
  always_comb begin
    sw = (src_w_q == '0) ? SrcSizeW'(1) :
         (src_w_q > SrcSizeW'(SrcDim)) ? SrcSizeW'(SrcDim) : src_w_q;
    sh = (src_h_q == '0) ? SrcSizeW'(1) :
         (src_h_q > SrcSizeW'(SrcDim)) ? SrcSizeW'(SrcDim) : src_h_q;
    dw = (dst_w_q == '0) ? DstSizeW'(1) :
         (dst_w_q > DstSizeW'(DstDim)) ? DstSizeW'(DstDim) : dst_w_q;
    dh = (dst_h_q == '0) ? DstSizeW'(1) :
         (dst_h_q > DstSizeW'(DstDim)) ? DstSizeW'(DstDim) : dst_h_q;
  end

  // stage 0: numerator product (2d+1)*S
  logic                s0_vld_q;
  load_t               s0_ld_q;
  logic [SrcSizeW-1:0] s0_sw_q, s0_sh_q;
  logic [DstSizeW-1:0] s0_dw_q, s0_dh_q;
  logic [NumW-1:0]     s0_npx_q, s0_npy_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) s0_vld_q <= 1'b0;
    else if (en) s0_vld_q <= in_valid_i;
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      s0_ld_q  <= '{op: in_item_i.operation, lx: in_item_i.load_x, ly: in_item_i.load_y,
                    rgb: {in_item_i.load_red, in_item_i.load_green, in_item_i.load_blue}};
      s0_sw_q  <= sw;
      s0_sh_q  <= sh;
      s0_dw_q  <= dw;
      s0_dh_q  <= dh;
      s0_npx_q <= NumW'({in_item_i.req_x, 1'b1}) * NumW'(sw);
      s0_npy_q <= NumW'({in_item_i.req_y, 1'b1}) * NumW'(sh);
    end
  end

  // stage 1: subtract D, set up the divider
  div_t div_d0;
  logic [NumW-1:0] numx, numy;
  logic [DenW-1:0] denx, deny;
  always_comb begin
    numx = (s0_npx_q > NumW'(s0_dw_q)) ? s0_npx_q - NumW'(s0_dw_q) : '0;
    numy = (s0_npy_q > NumW'(s0_dh_q)) ? s0_npy_q - NumW'(s0_dh_q) : '0;
    denx = {s0_dw_q, 1'b0};
    deny = {s0_dh_q, 1'b0};
    div_d0.ld   = s0_ld_q;
    div_d0.sw   = s0_sw_q;
    div_d0.sh   = s0_sh_q;
    div_d0.denx = denx;
    div_d0.deny = deny;
    // integer part above 255 always clamps to the edge pixel
    div_d0.ovfx = numx >= {denx, 8'b0};
    div_d0.ovfy = numy >= {deny, 8'b0};
    div_d0.remx = {numx, 8'b0};
    div_d0.remy = {numy, 8'b0};
    div_d0.qx   = '0;
    div_d0.qy   = '0;
  end

  logic vld_q [QuotW+1];
  div_t dv_q  [QuotW+1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) vld_q[0] <= 1'b0;
    else if (en) vld_q[0] <= s0_vld_q;
  end
  always_ff @(posedge clk_i) begin
    if (en) dv_q[0] <= div_d0;
  end

  // one quotient bit per stage, both axes side by side
  for (genvar i = 1; i <= QuotW; i++) begin : g_div
    localparam int unsigned K = QuotW - i;
    div_t d;
    logic [RemW-1:0] shx, shy;
    always_comb begin
      d   = dv_q[i-1];
      shx = RemW'(dv_q[i-1].denx) << K;
      shy = RemW'(dv_q[i-1].deny) << K;
      if (dv_q[i-1].remx >= shx) begin
        d.remx  = dv_q[i-1].remx - shx;
        d.qx[K] = 1'b1;
      end
      if (dv_q[i-1].remy >= shy) begin
        d.remy  = dv_q[i-1].remy - shy;
        d.qy[K] = 1'b1;
      end
    end
    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) vld_q[i] <= 1'b0;
      else if (en) vld_q[i] <= vld_q[i-1];
    end
    always_ff @(posedge clk_i) begin
      if (en) dv_q[i] <= d;
    end
  end

  // stage A: neighbors and fractions
  div_t dq;
  assign dq = dv_q[QuotW];

  logic [CoordW-1:0] lastx, lasty, x0, y0, x1, y1, fx, fy;
  always_comb begin
    lastx = CoordW'(dq.sw - SrcSizeW'(1));
    lasty = CoordW'(dq.sh - SrcSizeW'(1));
    x0 = (dq.ovfx || dq.qx[15:8] > lastx) ? lastx : dq.qx[15:8];
    y0 = (dq.ovfy || dq.qy[15:8] > lasty) ? lasty : dq.qy[15:8];
    x1 = (SrcSizeW'(x0) + SrcSizeW'(1) < dq.sw) ? x0 + CoordW'(1) : lastx;
    y1 = (SrcSizeW'(y0) + SrcSizeW'(1) < dq.sh) ? y0 + CoordW'(1) : lasty;
    fx = dq.ovfx ? '0 : dq.qx[7:0];
    fy = dq.ovfy ? '0 : dq.qy[7:0];
  end

  logic              a_vld_q;
  load_t             a_ld_q;
  logic [CoordW-1:0] a_x0_q, a_x1_q, a_y0_q, a_y1_q, a_fx_q, a_fy_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) a_vld_q <= 1'b0;
    else if (en) a_vld_q <= vld_q[QuotW];
  end
  always_ff @(posedge clk_i) begin
    if (en) begin
      a_ld_q <= dq.ld;
      a_x0_q <= x0;
      a_x1_q <= x1;
      a_y0_q <= y0;
      a_y1_q <= y1;
      a_fx_q <= fx;
      a_fy_q <= fy;
    end
  end

  // stage M: four banks by row and column parity; loads write here too
  logic [23:0] bank_rd [4];
  for (genvar b = 0; b < 4; b++) begin : g_bank
    localparam logic BX = 1'(b % 2);
    localparam logic BY = 1'(b / 2);
    logic [23:0]          mem [BankDepth];
    logic [CoordW-1:0]    rx, ry;
    logic                 we;
    assign rx = (a_x0_q[0] == BX) ? a_x0_q : a_x1_q;
    assign ry = (a_y0_q[0] == BY) ? a_y0_q : a_y1_q;
    assign we = a_vld_q && (a_ld_q.op == OP_LOAD) &&
                (a_ld_q.lx[0] == BX) && (a_ld_q.ly[0] == BY);
    always_ff @(posedge clk_i) begin
      if (en) begin
        if (we) mem[{a_ld_q.ly[7:1], a_ld_q.lx[7:1]}] <= a_ld_q.rgb;
        bank_rd[b] <= mem[{ry[7:1], rx[7:1]}];
      end
    end
  end

  logic        m_vld_q, m_op_q;
  logic [1:0]  m_px_q, m_py_q;
  logic [16:0] m_w_q [4];
  logic [8:0]  wx0, wy0;
  assign wx0 = 9'd256 - 9'(a_fx_q);
  assign wy0 = 9'd256 - 9'(a_fy_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) m_vld_q <= 1'b0;
    else if (en) m_vld_q <= a_vld_q;
  end
  always_ff @(posedge clk_i) begin
    if (en) begin
      m_op_q   <= a_ld_q.op;
      m_px_q   <= {a_x1_q[0], a_x0_q[0]};
      m_py_q   <= {a_y1_q[0], a_y0_q[0]};
      m_w_q[0] <= 17'(wx0) * 17'(wy0);
      m_w_q[1] <= 17'(a_fx_q) * 17'(wy0);
      m_w_q[2] <= 17'(wx0) * 17'(a_fy_q);
      m_w_q[3] <= 17'(a_fx_q) * 17'(a_fy_q);
    end
  end

  // stage P: twelve products
  logic [23:0] pix [4];
  assign pix[0] = bank_rd[{m_py_q[0], m_px_q[0]}];
  assign pix[1] = bank_rd[{m_py_q[0], m_px_q[1]}];
  assign pix[2] = bank_rd[{m_py_q[1], m_px_q[0]}];
  assign pix[3] = bank_rd[{m_py_q[1], m_px_q[1]}];

  logic        p_vld_q, p_op_q;
  logic [24:0] p_prod_q [4][3];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) p_vld_q <= 1'b0;
    else if (en) p_vld_q <= m_vld_q;
  end
  for (genvar n = 0; n < 4; n++) begin : g_prod
    for (genvar c = 0; c < 3; c++) begin : g_ch
      always_ff @(posedge clk_i) begin
        if (en) p_prod_q[n][c] <= 25'(pix[n][23-8*c -: 8]) * 25'(m_w_q[n]);
      end
    end
  end
  always_ff @(posedge clk_i) begin
    if (en) p_op_q <= m_op_q;
  end

  // output register: sum and drop 16 fraction bits
  logic [26:0] acc [3];
  for (genvar c = 0; c < 3; c++) begin : g_sum
    assign acc[c] = 27'(p_prod_q[0][c]) + 27'(p_prod_q[1][c]) +
                    27'(p_prod_q[2][c]) + 27'(p_prod_q[3][c]);
  end

  logic      out_vld_q;
  out_item_t out_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) out_vld_q <= 1'b0;
    else if (en) out_vld_q <= p_vld_q && (p_op_q == OP_REQUEST);
  end
  always_ff @(posedge clk_i) begin
    if (en) out_q <= '{out_red: acc[0][23:16], out_green: acc[1][23:16],
                       out_blue: acc[2][23:16]};
  end

  assign out_valid_o = out_vld_q;
  assign out_item_o  = out_q;

endmodule

// ===== rtl/biu_checker.sv =====
module biu_checker (
  input logic                         clk_i,
  input logic                         rst_ni,
  input logic                         in_stall_o,
  input logic                         out_valid_o,
  input logic                         out_stall_i,
  input biu_pkg::out_item_t           out_item_o,
  input logic                         cfg_ready_o
);
  import biu_pkg::*;

  // input stalls only because a finished result is held
  a_stall_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> (out_valid_o && out_stall_i))
    else $error("input stalled without a held result");

  a_cfg_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cfg_ready_o)
    else $error("configuration port not ready");

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_stall_i) |=> out_valid_o)
    else $error("result dropped while stalled");

  a_out_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_stall_i) |=> $stable(out_item_o))
    else $error("result changed while stalled");

endmodule

bind bilinear_image_upsampler biu_checker u_biu_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_stall_o  (in_stall_o),
  .out_valid_o (out_valid_o),
  .out_stall_i (out_stall_i),
  .out_item_o  (out_item_o),
  .cfg_ready_o (cfg_ready_o)
);

// ===== tb/bilinear_image_upsampler_tb.sv =====
`timescale 1ns / 100ps

module bilinear_image_upsampler_tb;
  import biu_pkg::*;

  localparam int unsigned StallLimit = 3000;
  localparam int unsigned DrainWait = 30;
  localparam int unsigned HoldLen = 400;
  localparam logic [CfgIndexW-1:0] CFG_UNUSED = 8'd77;

  logic clk;
  logic rst_n;
  logic in_valid;
  logic in_stall;
  in_item_t in_item;
  logic out_valid;
  logic out_stall;
  out_item_t out_item;
  logic cfg_valid;
  logic cfg_ready;
  logic [CfgIndexW-1:0] cfg_index;
  logic [CfgDataW-1:0] cfg_data;

  bilinear_image_upsampler dut (
    .clk_i(clk),
    .rst_ni(rst_n),
    .in_valid_i(in_valid),
    .in_stall_o(in_stall),
    .in_item_i(in_item),
    .out_valid_o(out_valid),
    .out_stall_i(out_stall),
    .out_item_o(out_item),
    .cfg_valid_i(cfg_valid),
    .cfg_ready_o(cfg_ready),
    .cfg_index_i(cfg_index),
    .cfg_data_i(cfg_data)
  );

  // predictor state
  logic [23:0] pix_mem [0:65535];
  logic [8:0] m_src_w, m_src_h;
  logic [12:0] m_dst_w, m_dst_h;

  in_item_t item_feed_q[$];
  out_item_t rgb_due_q[$];
  int unsigned n_queued;
  int unsigned n_taken;
  int unsigned n_errors;
  int unsigned idle_cycles;
  logic in_fire, cfg_fire;
  int quiet;
  int hold_req, hold_ack, hold_left;

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  function automatic int unsigned clamp_size(input int unsigned v, input int unsigned maxv);
    if (v == 0) return 1;
    if (v > maxv) return maxv;
    return v;
  endfunction

  function automatic void map_coord(input int unsigned d, input int unsigned s,
                                    input int unsigned dsz, output int unsigned lo,
                                    output int unsigned hi, output int unsigned fr);
    longint unsigned npos, den, num, ip, f;
    npos = (2 * longint'(d) + 1) * longint'(s);
    den = 2 * longint'(dsz);
    ip = 0;
    f = 0;
    if (npos > dsz) begin
      num = npos - dsz;
      ip = num / den;
      f = ((num % den) * 256) / den;
    end
    if (ip > s - 1) ip = s - 1;
    lo = 32'(ip);
    hi = (lo + 1 < s) ? lo + 1 : s - 1;
    fr = 32'(f & 8'hFF);
  endfunction

  function automatic out_item_t interp_pixel(input logic [11:0] rx, input logic [11:0] ry);
    int unsigned sw, sh, dw, dh, x0, x1, fx, y0, y1, fy;
    longint unsigned w00, w10, w01, w11, acc;
    logic [23:0] p00, p10, p01, p11;
    logic [23:0] rgb;
    sw = clamp_size(m_src_w, SrcDim);
    sh = clamp_size(m_src_h, SrcDim);
    dw = clamp_size(m_dst_w, DstDim);
    dh = clamp_size(m_dst_h, DstDim);
    map_coord(rx, sw, dw, x0, x1, fx);
    map_coord(ry, sh, dh, y0, y1, fy);
    w00 = (256 - fx) * (256 - fy);
    w10 = fx * (256 - fy);
    w01 = (256 - fx) * fy;
    w11 = fx * fy;
    p00 = pix_mem[y0 * SrcDim + x0];
    p10 = pix_mem[y0 * SrcDim + x1];
    p01 = pix_mem[y1 * SrcDim + x0];
    p11 = pix_mem[y1 * SrcDim + x1];
    for (int c = 0; c < 3; c++) begin
      acc = p00[8*c +: 8] * w00 + p10[8*c +: 8] * w10 + p01[8*c +: 8] * w01
          + p11[8*c +: 8] * w11;
      rgb[8*c +: 8] = acc[23:16];
    end
    return rgb;
  endfunction

  // reference, check and watchdog on the rising edge
  always @(posedge clk) begin
    out_item_t exp_px;
    in_fire <= in_valid && !in_stall;
    cfg_fire <= cfg_valid && cfg_ready;
    if (rst_n) begin
      if (out_valid && !out_stall) begin
        if (rgb_due_q.size() == 0) begin
          $display("%0t: unexpected item red %0d green %0d blue %0d", $time,
                   out_item.out_red, out_item.out_green, out_item.out_blue);
          n_errors++;
        end else begin
          exp_px = rgb_due_q.pop_front();
          if (out_item.out_red !== exp_px.out_red) begin
            $display("%0t: red expected %0d actual %0d", $time, exp_px.out_red,
                     out_item.out_red);
            n_errors++;
          end
          if (out_item.out_green !== exp_px.out_green) begin
            $display("%0t: green expected %0d actual %0d", $time, exp_px.out_green,
                     out_item.out_green);
            n_errors++;
          end
          if (out_item.out_blue !== exp_px.out_blue) begin
            $display("%0t: blue expected %0d actual %0d", $time, exp_px.out_blue,
                     out_item.out_blue);
            n_errors++;
          end
        end
      end
      if (in_valid && !in_stall) begin
        n_taken++;
        if (in_item.operation == OP_LOAD)
          pix_mem[in_item.load_y * SrcDim + in_item.load_x] =
            {in_item.load_red, in_item.load_green, in_item.load_blue};
        else
          rgb_due_q.push_back(interp_pixel(in_item.req_x, in_item.req_y));
      end
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          CFG_SRC_WIDTH: m_src_w = cfg_data[8:0];
          CFG_SRC_HEIGHT: m_src_h = cfg_data[8:0];
          CFG_DST_WIDTH: m_dst_w = cfg_data;
          CFG_DST_HEIGHT: m_dst_h = cfg_data;
          default: ;
        endcase
      end
      if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready))
        idle_cycles = 0;
      else
        idle_cycles++;
      if (idle_cycles >= StallLimit) begin
        $display("FAILURE");
        $finish;
      end
    end
  end

  // sender
  always @(negedge clk) begin
    if (rst_n && (!in_valid || in_fire)) begin
      if (item_feed_q.size() != 0 && (quiet != 0 || $urandom_range(0, 99) >= 23)) begin
        in_item <= item_feed_q.pop_front();
        in_valid <= 1'b1;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // receiver
  always @(negedge clk) begin
    if (hold_req != hold_ack) begin
      hold_ack = hold_req;
      hold_left = HoldLen;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_stall <= 1'b1;
    end else begin
      out_stall <= (quiet == 0) && ($urandom_range(0, 99) < 23);
    end
  end

  function automatic logic [7:0] pick_color();
    case ($urandom_range(0, 9))
      0: return 8'd0;
      1: return 8'd255;
      default: return 8'($urandom);
    endcase
  endfunction

  task automatic push_load(input int unsigned x, input int unsigned y);
    in_item_t it;
    it = in_item_t'({$urandom, $urandom});
    it.operation = OP_LOAD;
    it.load_x = 8'(x);
    it.load_y = 8'(y);
    it.load_red = pick_color();
    it.load_green = pick_color();
    it.load_blue = pick_color();
    item_feed_q.push_back(it);
    n_queued++;
  endtask

  task automatic push_req(input int unsigned x, input int unsigned y);
    in_item_t it;
    it = in_item_t'({$urandom, $urandom});
    it.operation = OP_REQUEST;
    it.req_x = 12'(x);
    it.req_y = 12'(y);
    item_feed_q.push_back(it);
    n_queued++;
  endtask

  task automatic drain();
    do @(negedge clk); while (n_taken != n_queued || rgb_due_q.size() != 0);
    repeat (DrainWait) @(negedge clk);
  endtask

  task automatic reg_write(input logic [CfgIndexW-1:0] idx, input int unsigned val);
    cfg_index <= idx;
    cfg_data <= CfgDataW'(val);
    cfg_valid <= 1'b1;
    do @(negedge clk); while (!cfg_fire);
  endtask

  // Drain, configure, fill the used source region, request three fixed positions, then mix requests and loads.
  task automatic run_scene(input int unsigned sw, input int unsigned sh, input int unsigned dw,
                           input int unsigned dh, input int unsigned n_mix);
    int unsigned esw, esh, edw, edh;
    drain();
    reg_write(CFG_SRC_WIDTH, sw);
    reg_write(CFG_SRC_HEIGHT, sh);
    reg_write(CFG_DST_WIDTH, dw);
    reg_write(CFG_DST_HEIGHT, dh);
    reg_write(CFG_UNUSED, $urandom);
    cfg_valid <= 1'b0;
    esw = clamp_size(sw[8:0], SrcDim);
    esh = clamp_size(sh[8:0], SrcDim);
    edw = clamp_size(dw[12:0], DstDim);
    edh = clamp_size(dh[12:0], DstDim);
    for (int y = 0; y < esh; y++)
      for (int x = 0; x < esw; x++)
        push_load(x, y);
    push_req(0, 0);
    push_req(edw - 1, edh - 1);
    push_req(4095, 4095);
    for (int i = 0; i < n_mix; i++) begin
      case ($urandom_range(0, 19))
        0: push_load($urandom_range(0, 255), $urandom_range(0, 255));
        1, 2: push_load($urandom_range(0, esw - 1), $urandom_range(0, esh - 1));
        3, 4: push_req($urandom_range(0, 4095), $urandom_range(0, 4095));
        default: push_req($urandom_range(0, edw - 1), $urandom_range(0, edh - 1));
      endcase
    end
  endtask

  initial begin
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_item = '0;
    out_stall = 1'b0;
    cfg_valid = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    n_queued = 0;
    n_taken = 0;
    n_errors = 0;
    idle_cycles = 0;
    quiet = 0;
    hold_req = 0;
    hold_ack = 0;
    hold_left = 0;
    in_fire = 1'b0;
    cfg_fire = 1'b0;
    m_src_w = 9'd256;
    m_src_h = 9'd256;
    m_dst_w = 13'd256;
    m_dst_h = 13'd256;
    repeat (12) @(negedge clk);
    rst_n = 1'b1;

    run_scene(4, 3, 9, 7, 10);
    push_req(4095, 0);
    push_req(0, 4095);
    push_req(8, 6);
    run_scene(1, 256, 1, 4096, 90);
    @(posedge clk);
    hold_req++;
    run_scene(256, 1, 4096, 1, 90);
    run_scene(0, 0, 0, 8191, 40);
    run_scene(511, 1, 8191, 0, 40);
    quiet = 1;
    run_scene(3, 2, 6, 4, 150);
    drain();
    quiet = 0;
    for (int k = 0; k < 5; k++) begin
      int unsigned sw, sh;
      sw = $urandom_range(1, 12);
      sh = $urandom_range(1, 12);
      if (k % 3 == 0)
        run_scene(sw, sh, $urandom_range(1, 4096), $urandom_range(1, 4096), 80);
      else
        run_scene(sw, sh, $urandom_range(1, sw * 5), $urandom_range(1, sh * 5), 80);
    end
    drain();
    if (n_errors == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
rtl/biu_pkg.sv
rtl/bilinear_image_upsampler.sv
rtl/biu_checker.sv
tb/bilinear_image_upsampler_tb.sv
